@@ hw/rtl/swrr_pkg.sv @@
// Shared types and codes for the smooth weighted round-robin pool.
// No dependencies; used by the datapath unit, the top level and the checker.
`timescale 1ns / 1ps

package swrr_pkg;

   localparam int RW_WIDTH    = 12;
   localparam int WT_WIDTH    = 8;
   localparam int TALLY_WIDTH = 17;
   localparam int CFG_WIDTH   = 64;
   localparam int ADDR_WIDTH  = 6;

   localparam logic [1:0] ST_GRANTED  = 2'd0;
   localparam logic [1:0] ST_NO_GRANT = 2'd1;
   localparam logic [1:0] ST_RELEASED = 2'd2;

   localparam logic [2:0] REG_WRITE_WEIGHTS = 3'd0;
   localparam logic [2:0] REG_READ_WEIGHTS  = 3'd1;
   localparam logic [2:0] REG_WRITE_COUNT   = 3'd2;
   localparam logic [2:0] REG_READ_COUNT    = 3'd3;
   localparam logic [2:0] REG_MAX_USE_COUNT = 3'd4;

   localparam logic OP_ACQUIRE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   typedef struct packed {
      logic       op;
      logic       want_write;
      logic       release_pool;
      logic [2:0] release_entry;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       granted_pool;
      logic [2:0] granted_entry;
      logic       reconnect;
   } rsp_type;

endpackage

@@ hw/rtl/swrr_alu.sv @@
// Shared saturating add/subtract and compare unit for running weights.
// Depends on swrr_pkg for widths.
`timescale 1ns / 1ps

module swrr_alu (
   input  logic                                     settle,
   input  logic signed [swrr_pkg::RW_WIDTH-1:0]     op_a,
   input  logic        [swrr_pkg::RW_WIDTH-1:0]     op_b,
   input  logic signed [swrr_pkg::RW_WIDTH-1:0]     best_val,
   output logic signed [swrr_pkg::RW_WIDTH-1:0]     result,
   output logic                                     better
);

   localparam int SW = swrr_pkg::RW_WIDTH + 2;
   localparam logic signed [SW-1:0] SAT_HI = SW'(2047);
   localparam logic signed [SW-1:0] SAT_LO = -SW'(2048);

   logic signed [SW-1:0] ext_a;
   logic signed [SW-1:0] ext_b;
   logic signed [SW-1:0] raw;

   assign ext_a = SW'(op_a);
   assign ext_b = $signed({2'b00, op_b});
   assign raw   = settle ? (ext_a - ext_b) : (ext_a + ext_b);

   always_comb begin
      if (raw > SAT_HI) begin
         result = SAT_HI[swrr_pkg::RW_WIDTH-1:0];
      end else if (raw < SAT_LO) begin
         result = SAT_LO[swrr_pkg::RW_WIDTH-1:0];
      end else begin
         result = raw[swrr_pkg::RW_WIDTH-1:0];
      end
   end

   assign better = best_val < result;

endmodule

@@ hw/rtl/smooth_weighted_round_robin_pool.sv @@
// Smooth weighted round-robin pool arbiter: after a decide state an acquire
// scans its n entries one per cycle and settles the winner in a finish state,
// repeating both for each further round; a release or an immediate no-grant is
// answered from decide. One item at a time, busy meanwhile. Rounds per acquire
// are capped at MAX_ROUNDS. Results cannot be stalled. Synchronous active-high
// reset clears busy marks and tallies and loads the default weights and counts.
`timescale 1ns / 1ps

module smooth_weighted_round_robin_pool #(
   parameter int MAX_ENTRIES = 8,
   parameter int MAX_ROUNDS  = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  swrr_pkg::req_type                     req_item,
   output logic                                  rsp_valid,
   output swrr_pkg::rsp_type                     rsp_item,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [swrr_pkg::ADDR_WIDTH-1:0]       paddr,
   input  logic [swrr_pkg::CFG_WIDTH-1:0]        pwdata,
   output logic [swrr_pkg::CFG_WIDTH-1:0]        prdata,
   output logic                                  pready
);

   localparam int EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int RCW = $clog2(MAX_ROUNDS);
   localparam int RWW = swrr_pkg::RW_WIDTH;
   localparam int TW  = swrr_pkg::TALLY_WIDTH;
   localparam logic [3:0]     CNT_MAX    = 4'(MAX_ENTRIES);
   localparam logic [RCW-1:0] ROUND_LAST = RCW'(MAX_ROUNDS - 1);
   localparam logic [63:0]    WT_RESET   = 64'h0101010101010101;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECIDE = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   swrr_pkg::req_type req_ff;
   logic [63:0] wweights_ff, rweights_ff;
   logic [3:0]  wcount_ff, rcount_ff;
   logic [15:0] maxuse_ff;

   logic signed [RWW-1:0] rw_ff [2][MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] busy_ff [2];
   logic [TW-1:0] tally_ff [2][MAX_ENTRIES];

   logic           pool_ff, pool_in;
   logic [EW-1:0]  last_ff, last_in;
   logic [EW-1:0]  scan_ff, scan_in;
   logic [EW-1:0]  best_ff, best_in;
   logic signed [RWW-1:0] bestval_ff, bestval_in;
   logic [RWW-1:0] total_ff, total_in;
   logic [RCW-1:0] round_ff, round_in;
   logic           rsp_valid_ff, rsp_valid_in;
   swrr_pkg::rsp_type rsp_item_ff, rsp_item_in;

   logic        cfg_wr;
   logic [2:0]  cfg_idx;
   logic [3:0]  rc_eff, wc_eff, n_eff;
   logic        pool_sel;
   logic [MAX_ENTRIES-1:0] free_mask;
   logic        any_free;
   logic [63:0] packed_w;
   logic [7:0]  weight;
   logic        finish;
   logic signed [RWW-1:0] alu_a;
   logic [RWW-1:0] alu_b;
   logic signed [RWW-1:0] alu_res;
   logic        alu_better;
   logic [TW-1:0] tally_cur, tally_inc;
   logic        over;
   logic        rel_ok;
   logic        do_scan, do_settle, do_grant, do_release;

   assign cfg_wr  = psel & penable & pwrite;
   assign cfg_idx = paddr[5:3];
   assign pready  = 1'b1;

   always_comb begin
      unique case (cfg_idx)
         swrr_pkg::REG_WRITE_WEIGHTS: prdata = wweights_ff;
         swrr_pkg::REG_READ_WEIGHTS:  prdata = rweights_ff;
         swrr_pkg::REG_WRITE_COUNT:   prdata = 64'(wcount_ff);
         swrr_pkg::REG_READ_COUNT:    prdata = 64'(rcount_ff);
         swrr_pkg::REG_MAX_USE_COUNT: prdata = 64'(maxuse_ff);
         default:                     prdata = '0;
      endcase
   end

   always_comb begin
      rc_eff = (rcount_ff > CNT_MAX) ? CNT_MAX : rcount_ff;
      if (wcount_ff == 4'd0) begin
         wc_eff = 4'd1;
      end else if (wcount_ff > CNT_MAX) begin
         wc_eff = CNT_MAX;
      end else begin
         wc_eff = wcount_ff;
      end
      pool_sel = !(req_ff.want_write || (rc_eff == 4'd0));
      n_eff    = pool_sel ? rc_eff : wc_eff;
      for (int e = 0; e < MAX_ENTRIES; e++) begin
         free_mask[e] = !busy_ff[pool_sel][e] && (4'(e) < n_eff);
      end
      any_free = |free_mask;
   end

   assign packed_w = pool_ff ? rweights_ff : wweights_ff;
   assign weight   = packed_w[{3'(scan_ff), 3'b000} +: 8];
   assign finish   = (state_ff == S_FINISH);
   assign alu_a    = finish ? bestval_ff : rw_ff[pool_ff][scan_ff];
   assign alu_b    = finish ? total_ff : RWW'(weight);

   swrr_alu u_alu (
      .settle   (finish),
      .op_a     (alu_a),
      .op_b     (alu_b),
      .best_val (bestval_ff),
      .result   (alu_res),
      .better   (alu_better)
   );

   assign tally_cur = tally_ff[pool_ff][best_ff];
   assign tally_inc = (tally_cur == '1) ? tally_cur : tally_cur + TW'(1);
   assign over      = (maxuse_ff != 16'd0) && (tally_inc > TW'(maxuse_ff));
   assign rel_ok    = 4'(req_ff.release_entry) < CNT_MAX;

   always_comb begin
      state_in     = state_ff;
      pool_in      = pool_ff;
      last_in      = last_ff;
      scan_in      = scan_ff;
      best_in      = best_ff;
      bestval_in   = bestval_ff;
      total_in     = total_ff;
      round_in     = round_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = '0;
      rsp_item_in.status = swrr_pkg::ST_NO_GRANT;
      do_scan      = 1'b0;
      do_settle    = 1'b0;
      do_grant     = 1'b0;
      do_release   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (req_ff.op == swrr_pkg::OP_RELEASE) begin
               do_release         = rel_ok;
               rsp_valid_in       = 1'b1;
               rsp_item_in.status = swrr_pkg::ST_RELEASED;
               state_in           = S_IDLE;
            end else if (!any_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               pool_in  = pool_sel;
               last_in  = EW'(n_eff - 4'd1);
               scan_in  = '0;
               round_in = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            do_scan  = 1'b1;
            total_in = ((scan_ff == '0) ? '0 : total_ff) + RWW'(weight);
            if (scan_ff == '0 || alu_better) begin
               best_in    = scan_ff;
               bestval_in = alu_res;
            end
            if (scan_ff == last_ff) begin
               state_in = S_FINISH;
            end else begin
               scan_in = scan_ff + EW'(1);
            end
         end
         S_FINISH: begin
            do_settle = 1'b1;
            if (!busy_ff[pool_ff][best_ff]) begin
               do_grant                  = 1'b1;
               rsp_valid_in              = 1'b1;
               rsp_item_in.status        = swrr_pkg::ST_GRANTED;
               rsp_item_in.granted_pool  = pool_ff;
               rsp_item_in.granted_entry = 3'(best_ff);
               rsp_item_in.reconnect     = over;
               state_in                  = S_IDLE;
            end else if (round_ff == ROUND_LAST) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               round_in = round_ff + RCW'(1);
               scan_in  = '0;
               state_in = S_SCAN;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         wweights_ff  <= WT_RESET;
         rweights_ff  <= WT_RESET;
         wcount_ff    <= 4'd1;
         rcount_ff    <= 4'd0;
         maxuse_ff    <= 16'd0;
         for (int p = 0; p < 2; p++) begin
            busy_ff[p] <= '0;
            for (int e = 0; e < MAX_ENTRIES; e++) begin
               rw_ff[p][e]    <= RWW'(WT_RESET[8*e +: 8]);
               tally_ff[p][e] <= '0;
            end
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_wr) begin
            unique case (cfg_idx)
               swrr_pkg::REG_WRITE_WEIGHTS: begin
                  wweights_ff <= pwdata;
                  for (int e = 0; e < MAX_ENTRIES; e++) begin
                     rw_ff[0][e] <= RWW'(pwdata[8*e +: 8]);
                  end
               end
               swrr_pkg::REG_READ_WEIGHTS: begin
                  rweights_ff <= pwdata;
                  for (int e = 0; e < MAX_ENTRIES; e++) begin
                     rw_ff[1][e] <= RWW'(pwdata[8*e +: 8]);
                  end
               end
               swrr_pkg::REG_WRITE_COUNT:   wcount_ff <= pwdata[3:0];
               swrr_pkg::REG_READ_COUNT:    rcount_ff <= pwdata[3:0];
               swrr_pkg::REG_MAX_USE_COUNT: maxuse_ff <= pwdata[15:0];
               default: ;
            endcase
         end
         if (do_scan) begin
            rw_ff[pool_ff][scan_ff] <= alu_res;
         end
         if (do_settle) begin
            rw_ff[pool_ff][best_ff] <= alu_res;
         end
         if (do_grant) begin
            busy_ff[pool_ff][best_ff]  <= 1'b1;
            tally_ff[pool_ff][best_ff] <= over ? '0 : tally_inc;
         end
         if (do_release) begin
            busy_ff[req_ff.release_pool][req_ff.release_entry[EW-1:0]] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && state_ff == S_IDLE) begin
         req_ff <= req_item;
      end
      pool_ff     <= pool_in;
      last_ff     <= last_in;
      scan_ff     <= scan_in;
      best_ff     <= best_in;
      bestval_ff  <= bestval_in;
      total_ff    <= total_in;
      round_ff    <= round_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

@@ hw/rtl/swrr_checker.sv @@
// Port-level checks for the smooth weighted round-robin pool, and their bind.
// Depends on swrr_pkg and the top level smooth_weighted_round_robin_pool.
`timescale 1ns / 1ps

module swrr_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input swrr_pkg::rsp_type rsp_item
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not make the block busy");

   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.status == swrr_pkg::ST_GRANTED ||
                     rsp_item.status == swrr_pkg::ST_NO_GRANT ||
                     rsp_item.status == swrr_pkg::ST_RELEASED))
      else $error("undefined status code");

   a_clean_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status != swrr_pkg::ST_GRANTED |->
         rsp_item.granted_pool == 1'b0 && rsp_item.granted_entry == 3'd0 &&
         rsp_item.reconnect == 1'b0)
      else $error("grant fields set on a result without a grant");

endmodule

bind smooth_weighted_round_robin_pool swrr_checker u_swrr_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

@@ tb/swrr_grant_checker.sv @@
// Grant checker for the smooth weighted round-robin pool: mirrors the register writes,
// predicts each item's result and compares it with the block's output.
// Depends on swrr_pkg for the item types, status codes and register indexes.
`timescale 1ns / 1ps

module swrr_grant_checker
   import swrr_pkg::*;
#(
   parameter int POOL_SIZE = 8,
   parameter int ROUND_CAP = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  req_type               req_item,
   input  logic                  rsp_valid,
   input  rsp_type               rsp_item,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [ADDR_WIDTH-1:0] paddr,
   input  logic [CFG_WIDTH-1:0]  pwdata,
   output int                    mismatches,
   output int                    outstanding
);

   localparam int SLOTS     = 8;
   localparam int RW_HI     = 2 ** (RW_WIDTH - 1) - 1;
   localparam int RW_LO     = -(2 ** (RW_WIDTH - 1));
   localparam int TALLY_TOP = 2 ** TALLY_WIDTH - 1;
   localparam logic [CFG_WIDTH-1:0] UNIT_WEIGHTS = 64'h0101_0101_0101_0101;

   logic [CFG_WIDTH-1:0] pool_weights [2];
   logic [3:0]           write_used;
   logic [3:0]           read_used;
   logic [15:0]          use_limit;
   int                   running [2*SLOTS];
   bit                   held [2*SLOTS];
   int                   uses [2*SLOTS];
   rsp_type              due_grants [$];
   int                   fails = 0;

   assign mismatches = fails;

   function automatic int saturate(input int v);
      if (v > RW_HI) return RW_HI;
      if (v < RW_LO) return RW_LO;
      return v;
   endfunction

   function automatic int weight_at(input int pool, input int e);
      return int'(pool_weights[pool][WT_WIDTH*e +: WT_WIDTH]);
   endfunction

   function automatic void reload(input int pool);
      for (int e = 0; e < SLOTS; e++) running[pool*SLOTS + e] = weight_at(pool, e);
   endfunction

   function automatic int clip_count(input int c, input int lo);
      if (c < lo) c = lo;
      if (c > POOL_SIZE) c = POOL_SIZE;
      return c;
   endfunction

   function automatic rsp_type arbitrate(input req_type r);
      rsp_type res;
      int      pool, n, base, best, total, w, k;
      bit      any_free;
      res = '0;
      res.status = ST_NO_GRANT;
      if (r.op == OP_RELEASE) begin
         if (int'(r.release_entry) < POOL_SIZE)
            held[int'(r.release_pool)*SLOTS + int'(r.release_entry)] = 1'b0;
         res.status = ST_RELEASED;
         return res;
      end
      pool = (r.want_write || clip_count(int'(read_used), 0) == 0) ? 0 : 1;
      n = pool ? clip_count(int'(read_used), 0) : clip_count(int'(write_used), 1);
      base = pool * SLOTS;
      any_free = 1'b0;
      for (int e = 0; e < n; e++) if (!held[base + e]) any_free = 1'b1;
      if (!any_free) return res;
      for (int round = 0; round < ROUND_CAP; round++) begin
         total = 0;
         best = 0;
         for (int e = 0; e < n; e++) begin
            w = weight_at(pool, e);
            running[base + e] = saturate(running[base + e] + w);
            total += w;
            if (running[base + best] < running[base + e]) best = e;
         end
         running[base + best] = saturate(running[base + best] - total);
         if (!held[base + best]) begin
            k = base + best;
            held[k] = 1'b1;
            if (uses[k] < TALLY_TOP) uses[k]++;
            if (use_limit != 0 && uses[k] > int'(use_limit)) begin
               uses[k] = 0;
               res.reconnect = 1'b1;
            end
            res.status        = ST_GRANTED;
            res.granted_pool  = pool[0];
            res.granted_entry = best[2:0];
            return res;
         end
      end
      return res;
   endfunction

   task automatic compare(input string field, input logic [2:0] want, input logic [2:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         pool_weights[0] = UNIT_WEIGHTS;
         pool_weights[1] = UNIT_WEIGHTS;
         write_used = 4'd1;
         read_used  = 4'd0;
         use_limit  = 16'd0;
         reload(0);
         reload(1);
         for (int k = 0; k < 2*SLOTS; k++) begin
            held[k] = 1'b0;
            uses[k] = 0;
         end
         due_grants.delete();
      end else begin
         if (rsp_valid) begin
            if (due_grants.size() == 0) begin
               $error("result with no item waiting: %p", rsp_item);
               fails++;
            end else begin
               want = due_grants.pop_front();
               compare("status", 3'(want.status), 3'(rsp_item.status));
               compare("granted_pool", 3'(want.granted_pool), 3'(rsp_item.granted_pool));
               compare("granted_entry", want.granted_entry, rsp_item.granted_entry);
               compare("reconnect", 3'(want.reconnect), 3'(rsp_item.reconnect));
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[ADDR_WIDTH-1:3])
               REG_WRITE_WEIGHTS: begin
                  pool_weights[0] = pwdata;
                  reload(0);
               end
               REG_READ_WEIGHTS: begin
                  pool_weights[1] = pwdata;
                  reload(1);
               end
               REG_WRITE_COUNT:   write_used = pwdata[3:0];
               REG_READ_COUNT:    read_used  = pwdata[3:0];
               REG_MAX_USE_COUNT: use_limit  = pwdata[15:0];
               default: ;
            endcase
         end
         if (start && !busy) due_grants.push_back(arbitrate(req_item));
      end
      outstanding = due_grants.size();
   end

endmodule

@@ tb/tb.sv @@
// Top of the pool arbiter test: clock, reset, register setup and item stimulus.
// Depends on swrr_pkg, smooth_weighted_round_robin_pool and swrr_grant_checker.
`timescale 1ns / 1ps

module tb;
   import swrr_pkg::*;

   localparam int ENTRIES     = 8;
   localparam int ROUNDS      = 4096;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 212;
   localparam int REQ_BITS    = $bits(req_type);
   localparam logic [2:0] REG_UNMAPPED = 3'd7;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_item;
   logic                  rsp_valid;
   rsp_type               rsp_item;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [ADDR_WIDTH-1:0] paddr;
   logic [CFG_WIDTH-1:0]  pwdata;
   logic [CFG_WIDTH-1:0]  prdata;
   logic                  pready;
   int                    mismatches;
   int                    outstanding;
   int                    w_used;
   int                    r_used;

   int write_count_plan [PHASES] = '{8, 1, 15, 0, 3, 5, 8, 0};
   int read_count_plan  [PHASES] = '{8, 0, 9, 3, 0, 1, 15, 0};
   int use_limit_plan   [PHASES] = '{0, 65535, 1, 2, 3, 0, 4, 0};

   smooth_weighted_round_robin_pool #(
      .MAX_ENTRIES(ENTRIES),
      .MAX_ROUNDS (ROUNDS)
   ) dut (.*);

   swrr_grant_checker #(
      .POOL_SIZE(ENTRIES),
      .ROUND_CAP(ROUNDS)
   ) grant_check (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000_000;
      $display("smooth_weighted_round_robin_pool test failed");
      $finish;
   end

   function automatic req_type noise_item();
      logic [REQ_BITS-1:0] bits;
      bits = REQ_BITS'($urandom);
      return bits;
   endfunction

   function automatic req_type take(input logic want_write);
      req_type it;
      it = noise_item();
      it.op = OP_ACQUIRE;
      it.want_write = want_write;
      return it;
   endfunction

   function automatic req_type give_back(input logic pool, input logic [2:0] entry);
      req_type it;
      it = noise_item();
      it.op = OP_RELEASE;
      it.release_pool = pool;
      it.release_entry = entry;
      return it;
   endfunction

   function automatic req_type random_item();
      req_type it;
      int      span;
      it = noise_item();
      if ($urandom_range(99) < 55) begin
         it.op = OP_ACQUIRE;
      end else begin
         it.op = OP_RELEASE;
         span = it.release_pool ? r_used : w_used;
         if (span > 0 && $urandom_range(9) < 8) it.release_entry = 3'($urandom_range(span - 1));
      end
      return it;
   endfunction

   task automatic issue(input req_type it);
      logic free;
      req_item <= it;
      start    <= 1'b1;
      do begin
         @(negedge clock);
         free = !busy;
         @(posedge clock);
      end while (!free);
   endtask

   task automatic pause(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain();
      logic idle;
      start <= 1'b0;
      do begin
         @(negedge clock);
         idle = (outstanding == 0) && !busy;
         @(posedge clock);
      end while (!idle);
   endtask

   task automatic set_reg(input logic [2:0] idx, input logic [CFG_WIDTH-1:0] value);
      logic ready;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(negedge clock);
         ready = pready;
         @(posedge clock);
      end while (!ready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [CFG_WIDTH-1:0] ww;
      logic [CFG_WIDTH-1:0] rdw;
      int                   wc;
      int                   rc;
      int                   lim;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_item <= '0;
      psel     <= 1'b0;
      penable  <= 1'b0;
      pwrite   <= 1'b0;
      paddr    <= '0;
      pwdata   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // defaults: one write entry, reads fall back to the write pool
      issue(take(1'b1));
      issue(take(1'b1));
      issue(take(1'b0));
      issue(give_back(1'b0, 3'd0));
      issue(take(1'b0));
      issue(give_back(1'b1, 3'd7));
      issue(give_back(1'b0, 3'd0));
      drain();

      // zero-weight neighbour: busy heavy entry runs into the round cap
      set_reg(REG_WRITE_WEIGHTS, 64'hFF);
      set_reg(REG_WRITE_COUNT, 64'd2);
      set_reg(REG_MAX_USE_COUNT, 64'd1);
      issue(take(1'b1));
      issue(take(1'b1));
      issue(give_back(1'b0, 3'd0));
      issue(take(1'b1));
      issue(give_back(1'b0, 3'd0));
      drain();

      // counts beyond range, all-zero and all-full weights, running weight saturation
      set_reg(REG_WRITE_WEIGHTS, '0);
      set_reg(REG_WRITE_COUNT, 64'd15);
      set_reg(REG_READ_WEIGHTS, '1);
      set_reg(REG_READ_COUNT, 64'd9);
      set_reg(REG_MAX_USE_COUNT, 64'hFFFF);
      set_reg(REG_UNMAPPED, '1);
      issue(take(1'b1));
      repeat (9) issue(take(1'b0));
      issue(give_back(1'b0, 3'd0));
      drain();

      set_reg(REG_WRITE_COUNT, 64'd0);
      issue(take(1'b1));
      issue(take(1'b1));

      for (int p = 0; p < PHASES; p++) begin
         drain();
         wc  = write_count_plan[p];
         rc  = read_count_plan[p];
         lim = use_limit_plan[p];
         if (p == PHASES - 1) begin
            wc  = $urandom_range(8, 1);
            rc  = $urandom_range(8);
            lim = $urandom_range(40, 1);
         end
         for (int e = 0; e < ENTRIES; e++) begin
            if (p == 0) begin
               ww[8*e +: 8]  = 8'hFF;
               rdw[8*e +: 8] = 8'hFF;
            end else if (p == 1) begin
               ww[8*e +: 8]  = 8'h01;
               rdw[8*e +: 8] = 8'h01;
            end else begin
               ww[8*e +: 8]  = 8'($urandom_range(255, 16));
               rdw[8*e +: 8] = 8'($urandom_range(255, 16));
            end
         end
         set_reg(REG_WRITE_WEIGHTS, ww);
         set_reg(REG_READ_WEIGHTS, rdw);
         set_reg(REG_WRITE_COUNT, CFG_WIDTH'(wc));
         set_reg(REG_READ_COUNT, CFG_WIDTH'(rc));
         set_reg(REG_MAX_USE_COUNT, CFG_WIDTH'(lim));
         w_used = (wc == 0) ? 1 : (wc > ENTRIES) ? ENTRIES : wc;
         r_used = (rc > ENTRIES) ? ENTRIES : rc;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            issue(random_item());
            if (p < PHASES - 1 && $urandom_range(3) == 0) pause($urandom_range(9, 1));
         end
      end

      drain();
      repeat (16) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("smooth_weighted_round_robin_pool test passed");
      end else begin
         $display("smooth_weighted_round_robin_pool test failed");
      end
      $finish;
   end

endmodule
